// ===== rtl/core/line_sensor_calibrate_and_locate_assert.svh =====
// Assertion macros used by the line sensor back end.
// Each macro checks an implication on the rising edge of clk while rst_n is high.
`ifndef LINE_SENSOR_CALIBRATE_AND_LOCATE_ASSERT_SVH
`define LINE_SENSOR_CALIBRATE_AND_LOCATE_ASSERT_SVH

// Same-cycle implication.
`define LSCA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line sensor assertion failed");

// Next-cycle implication.
`define LSCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line sensor assertion failed");

`endif

// ===== rtl/core/lsca_pkg.sv =====
// ----------------------------------------------------------------------------
// lsca_pkg
// Types and constants shared by the line sensor calibrate and locate block.
// ----------------------------------------------------------------------------
package lsca_pkg;

    localparam int SW              = 10;
    localparam int CH              = 8;
    localparam int CNT_W           = 4;
    localparam int POS_W           = 13;
    localparam int WEIGHT_W        = 15;
    localparam int IDXSUM_W        = 5;
    localparam int TOTAL_W         = 10;
    localparam int QUAL_W          = 7;

    localparam int POSITION_STEP   = 1000;
    localparam int CENTER_OFFSET   = 3500;
    localparam int POS_LIMIT       = 3500;
    localparam int START_THRESHOLD = 500;
    localparam int RANGE_MIN       = 150;
    localparam int LOW_BOUND       = 20;
    localparam int HIGH_BOUND      = 1000;
    localparam int Q_RANGE_MID     = 250;
    localparam int Q_RANGE_HIGH    = 400;
    localparam int Q_SCORE_LOW     = 50;
    localparam int Q_SCORE_MID     = 75;
    localparam int Q_SCORE_HIGH    = 100;

    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_CAL     = 2'd1;
    localparam logic [1:0] ACT_THRESH  = 2'd2;
    localparam logic [1:0] ACT_MEASURE = 2'd3;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_RATIO = 1'b1;
    localparam logic MODE_SIX  = 1'b1;

    typedef struct packed {
        logic [1:0]    action;
        logic [SW-1:0] sample_0;
        logic [SW-1:0] sample_1;
        logic [SW-1:0] sample_2;
        logic [SW-1:0] sample_3;
        logic [SW-1:0] sample_4;
        logic [SW-1:0] sample_5;
        logic [SW-1:0] sample_6;
        logic [SW-1:0] sample_7;
    } in_word_t;

    typedef struct packed {
        logic signed [POS_W-1:0] line_position;
        logic                    line_lost;
        logic [CNT_W-1:0]        black_count;
        logic                    calibration_ok;
        logic [QUAL_W-1:0]       quality;
    } out_word_t;

    typedef struct packed {
        logic [1:0]              action;
        logic [CH-1:0][SW-1:0]   s;
    } item_t;

    typedef struct packed {
        logic                start;
        logic [WEIGHT_W-1:0] dividend;
        logic [CNT_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [WEIGHT_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/core/lsca_front.sv =====
// ----------------------------------------------------------------------------
// lsca_front
// Accepts frames, fills in the averaged channels in six-channel mode and
// queues the decoded words for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module lsca_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              channel_mode,
    input  logic              push,
    output logic              full,
    input  lsca_pkg::in_word_t in_word,
    output logic              item_valid,
    input  logic              item_pop,
    output lsca_pkg::item_t   item
);
    import lsca_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    item_t      dec;
    logic [SW:0] sum_lo, sum_hi;
    logic       do_wr, do_rd;

    always_comb
    begin
        dec.action = in_word.action;
        dec.s[0] = in_word.sample_0;
        dec.s[1] = in_word.sample_1;
        dec.s[2] = in_word.sample_2;
        dec.s[3] = in_word.sample_3;
        dec.s[4] = in_word.sample_4;
        dec.s[5] = in_word.sample_5;
        dec.s[6] = in_word.sample_6;
        dec.s[7] = in_word.sample_7;
        sum_lo = {1'b0, in_word.sample_0} + {1'b0, in_word.sample_2};
        sum_hi = {1'b0, in_word.sample_5} + {1'b0, in_word.sample_7};
        if (channel_mode == MODE_SIX)
        begin
            dec.s[1] = sum_lo[SW:1];
            dec.s[6] = sum_hi[SW:1];
        end
    end

    assign full       = (fill_reg == 2'd2);
    assign item_valid = (fill_reg != 2'd0);
    assign item       = mem_reg[rd_ptr_reg];
    assign do_wr      = push && !full;
    assign do_rd      = item_pop && item_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ===== rtl/core/lsca_div.sv =====
// ----------------------------------------------------------------------------
// lsca_div
// Restoring divider, one quotient bit per cycle, shared by the quality
// average and the position average.
// ----------------------------------------------------------------------------
module lsca_div (
    input  logic               clk,
    input  logic               rst_n,
    input  lsca_pkg::div_req_t req,
    output lsca_pkg::div_rsp_t rsp
);
    import lsca_pkg::*;

    localparam logic [CNT_W-1:0] STEPS = CNT_W'(WEIGHT_W);

    logic [WEIGHT_W-1:0] quo_reg;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    dvs_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W:0]      rem_sh;
    logic                qbit;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[WEIGHT_W-1]};
        qbit     = (rem_sh >= {1'b0, dvs_reg});
        rem_next = qbit ? CNT_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= STEPS;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[WEIGHT_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/core/lsca_back.sv =====
// ----------------------------------------------------------------------------
// lsca_back
// Holds the per-channel calibration state, carries out each queued word and
// computes the calibration check, quality score and line position.
// ----------------------------------------------------------------------------
module lsca_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          ratio_code,
    input  logic                item_valid,
    output logic                item_pop,
    input  lsca_pkg::item_t     item,
    output lsca_pkg::div_req_t  div_req,
    input  lsca_pkg::div_rsp_t  div_rsp,
    output logic                res_push,
    input  logic                res_full,
    output lsca_pkg::out_word_t res_word
);
    import lsca_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_QDIV = 3'd3;
    localparam logic [2:0] S_PDIV = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [SW-1:0] SMASK = {SW{1'b1}};

    logic [2:0]              state_reg, state_next;
    item_t                   item_reg;
    logic [SW-1:0]           min_reg [CH];
    logic [SW-1:0]           max_reg [CH];
    logic [SW-1:0]           th_reg  [CH];
    logic signed [POS_W-1:0] held_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [WEIGHT_W-1:0]     weight_reg;
    logic                    ok_reg;
    logic [CNT_W-1:0]        valid_reg;
    logic [QUAL_W-1:0]       qual_reg;
    logic                    lost_reg;

    // Action results
    logic [SW-1:0]           th_new [CH];
    logic [2:0]              shift_k;
    logic [CNT_W-1:0]        lit_count;
    logic [IDXSUM_W-1:0]     idx_sum;

    // Post-action evaluation
    logic                    cal_ok;
    logic [TOTAL_W-1:0]      total;
    logic [CNT_W-1:0]        valid_cnt;

    logic [QUAL_W-1:0]       qual_div;
    logic [QUAL_W+CNT_W-1:0] qual_prod;
    logic [QUAL_W-1:0]       qual_final;
    logic signed [WEIGHT_W+1:0] pos_raw;
    logic signed [POS_W-1:0] pos_clamped;
    logic                    need_pos;

    always_comb
    begin
        logic [WEIGHT_W-1:0] mx;
        logic [WEIGHT_W-1:0] acc;
        shift_k   = 3'd4 - {1'b0, ratio_code};
        lit_count = '0;
        idx_sum   = '0;
        for (int i = 0; i < CH; i++)
        begin
            mx  = WEIGHT_W'(max_reg[i]);
            acc = (mx << shift_k) - mx + WEIGHT_W'(min_reg[i]);
            th_new[i] = SW'(acc >> shift_k);
            if (item_reg.s[i] > th_reg[i])
            begin
                lit_count = lit_count + 1'b1;
                idx_sum   = idx_sum + IDXSUM_W'(i);
            end
        end
    end

    always_comb
    begin
        logic signed [SW:0] range;
        cal_ok    = 1'b1;
        total     = '0;
        valid_cnt = '0;
        for (int i = 0; i < CH; i++)
        begin
            range = $signed({1'b0, max_reg[i]}) - $signed({1'b0, min_reg[i]});
            if (range < RANGE_MIN)
            begin
                cal_ok = 1'b0;
            end
            if (min_reg[i] < LOW_BOUND || max_reg[i] > HIGH_BOUND)
            begin
                cal_ok = 1'b0;
            end
            if (th_reg[i] <= min_reg[i] || th_reg[i] >= max_reg[i])
            begin
                cal_ok = 1'b0;
            end
            if (range >= RANGE_MIN)
            begin
                valid_cnt = valid_cnt + 1'b1;
                if (range < Q_RANGE_MID)
                begin
                    total = total + TOTAL_W'(Q_SCORE_LOW);
                end
                else if (range < Q_RANGE_HIGH)
                begin
                    total = total + TOTAL_W'(Q_SCORE_MID);
                end
                else
                begin
                    total = total + TOTAL_W'(Q_SCORE_HIGH);
                end
            end
        end
    end

    // A partial set of scoring channels is scaled by valid/8; eight is exact.
    always_comb
    begin
        qual_div  = div_rsp.quotient[QUAL_W-1:0];
        qual_prod = QUAL_W'(qual_div) * valid_cnt;
        if (valid_cnt == '0)
        begin
            qual_final = '0;
        end
        else if (valid_cnt == CNT_W'(CH))
        begin
            qual_final = qual_div;
        end
        else
        begin
            qual_final = QUAL_W'(qual_prod >> 3);
        end
        need_pos = (item_reg.action == ACT_MEASURE) && ok_reg && (count_reg != '0);
        pos_raw  = $signed({2'b00, div_rsp.quotient}) - (WEIGHT_W+2)'(CENTER_OFFSET);
        if (pos_raw < -POS_LIMIT)
        begin
            pos_clamped = POS_W'(-POS_LIMIT);
        end
        else if (pos_raw > POS_LIMIT)
        begin
            pos_clamped = POS_W'(POS_LIMIT);
        end
        else
        begin
            pos_clamped = pos_raw[POS_W-1:0];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        item_pop         = 1'b0;
        res_push         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = WEIGHT_W'(total);
        div_req.divisor  = (valid_cnt == '0) ? CNT_W'(1) : valid_cnt;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                div_req.start = 1'b1;
                state_next    = S_QDIV;
            end
            S_QDIV:
            begin
                if (div_rsp.done)
                begin
                    if (need_pos)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = weight_reg;
                        div_req.divisor  = count_reg;
                        state_next       = S_PDIV;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_PDIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg  <= '0;
            for (int i = 0; i < CH; i++)
            begin
                min_reg[i] <= SMASK;
                max_reg[i] <= '0;
                th_reg[i]  <= SW'(START_THRESHOLD);
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EXEC)
            begin
                unique case (item_reg.action)
                    ACT_CLEAR:
                    begin
                        for (int i = 0; i < CH; i++)
                        begin
                            min_reg[i] <= SMASK;
                            max_reg[i] <= '0;
                        end
                    end
                    ACT_CAL:
                    begin
                        for (int i = 0; i < CH; i++)
                        begin
                            if (item_reg.s[i] < min_reg[i])
                            begin
                                min_reg[i] <= item_reg.s[i];
                            end
                            if (item_reg.s[i] > max_reg[i])
                            begin
                                max_reg[i] <= item_reg.s[i];
                            end
                        end
                    end
                    ACT_THRESH:
                    begin
                        for (int i = 0; i < CH; i++)
                        begin
                            th_reg[i] <= th_new[i];
                        end
                    end
                    ACT_MEASURE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
            // Measure with a failed calibration check drops the held position.
            if (state_reg == S_QDIV && div_rsp.done
                && item_reg.action == ACT_MEASURE && !ok_reg)
            begin
                held_reg <= '0;
            end
            if (state_reg == S_PDIV && div_rsp.done)
            begin
                held_reg <= pos_clamped;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            item_reg <= item;
        end
        if (state_reg == S_EXEC)
        begin
            count_reg  <= (item_reg.action == ACT_MEASURE) ? lit_count : '0;
            weight_reg <= WEIGHT_W'(idx_sum * POSITION_STEP);
        end
        if (state_reg == S_EVAL)
        begin
            ok_reg    <= cal_ok;
            valid_reg <= valid_cnt;
        end
        if (state_reg == S_QDIV && div_rsp.done)
        begin
            qual_reg <= qual_final;
            lost_reg <= (item_reg.action == ACT_MEASURE) && ok_reg && (count_reg == '0);
        end
    end

    assign res_word.line_position  = held_reg;
    assign res_word.line_lost      = lost_reg;
    assign res_word.black_count    = count_reg;
    assign res_word.calibration_ok = ok_reg;
    assign res_word.quality        = qual_reg;

`include "line_sensor_calibrate_and_locate_assert.svh"

    `LSCA_ASSERT_NOW(a_lost_consistent, res_push && res_word.line_lost, res_word.black_count == '0 && res_word.calibration_ok)
    `LSCA_ASSERT_NOW(a_pos_bounds, res_push, res_word.line_position <= POS_LIMIT && res_word.line_position >= -POS_LIMIT)
    `LSCA_ASSERT_NOW(a_pdiv_has_count, state_reg == S_PDIV, count_reg != '0 && ok_reg)
    `LSCA_ASSERT_NOW(a_scorers_bounded, state_reg == S_OUT, valid_reg <= CNT_W'(CH) && qual_reg <= QUAL_W'(Q_SCORE_HIGH))

endmodule

// ===== rtl/core/line_sensor_calibrate_and_locate.sv =====
// ----------------------------------------------------------------------------
// line_sensor_calibrate_and_locate
// Line sensor calibration and weighted line position, with an APB register
// port and queue-style frame and result channels.
// ----------------------------------------------------------------------------
// A frame is taken into a two-entry input queue; the back end then works on
// one frame at a time. Each frame passes through the back end in order: apply
// action, evaluate, then a bit-serial divide for the quality average; a
// measure that finds the line adds a position divide on the same shared
// divider. Results wait in a two-entry output queue, so a stalled consumer
// does not stop frames being accepted until both queues fill. Registers:
// channel_mode at address 0, ratio_code at 4.
module line_sensor_calibrate_and_locate (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                push,
    output logic                full,
    input  lsca_pkg::in_word_t  in_word,
    output logic                empty,
    input  logic                pop,
    output lsca_pkg::out_word_t out_word
);
    import lsca_pkg::*;

    logic       mode_reg;
    logic [1:0] ratio_reg;
    logic       cfg_wr;

    logic       item_valid, item_pop;
    item_t      item;
    div_req_t   div_req;
    div_rsp_t   div_rsp;
    logic       res_push, res_full;
    out_word_t  res_word;

    out_word_t  oq_reg [2];
    logic       oq_wr_reg, oq_rd_reg;
    logic [1:0] oq_fill_reg;
    logic       oq_do_rd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SIX;
            ratio_reg <= 2'd0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_MODE:  mode_reg  <= pwdata[0];
                REG_RATIO: ratio_reg <= pwdata[1:0];
                default:   mode_reg  <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MODE:  prdata = {31'd0, mode_reg};
            REG_RATIO: prdata = {30'd0, ratio_reg};
            default:   prdata = '0;
        endcase
    end

    lsca_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .channel_mode (mode_reg),
        .push         (push),
        .full         (full),
        .in_word      (in_word),
        .item_valid   (item_valid),
        .item_pop     (item_pop),
        .item         (item)
    );

    lsca_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    lsca_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ratio_code (ratio_reg),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .res_push   (res_push),
        .res_full   (res_full),
        .res_word   (res_word)
    );

    // Result queue
    assign res_full = (oq_fill_reg == 2'd2);
    assign empty    = (oq_fill_reg == 2'd0);
    assign oq_do_rd = pop && !empty;
    assign out_word = oq_reg[oq_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg   <= 1'b0;
            oq_rd_reg   <= 1'b0;
            oq_fill_reg <= 2'd0;
        end
        else
        begin
            if (res_push)
            begin
                oq_wr_reg <= !oq_wr_reg;
            end
            if (oq_do_rd)
            begin
                oq_rd_reg <= !oq_rd_reg;
            end
            oq_fill_reg <= oq_fill_reg + 2'(res_push) - 2'(oq_do_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            oq_reg[oq_wr_reg] <= res_word;
        end
    end

endmodule
